@@ design/wcbb_pkg.sv @@
// wcbb_pkg: shared types and constants of the wrap/clamp three-pass box blur
// depends on nothing; used by wrap_clamp_triple_box_blur
package wcbb_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int DEF_MAX_RADIUS = 255;
  localparam int DEF_PASS_COUNT = 3;

  localparam int CH_W   = 16;
  localparam int NUM_CH = 4;
  localparam int PIX_W  = CH_W * NUM_CH;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic [8:0] RST_WIDTH  = 9'd256;
  localparam logic [7:0] RST_HEIGHT = 8'd128;
  localparam logic [7:0] RST_RADIUS = 8'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_MOD,
    ST_INIT_RD,
    ST_INIT_ACC,
    ST_DIV_LD,
    ST_DIV,
    ST_WR,
    ST_ADD_RD,
    ST_ADD_ACC,
    ST_DROP_RD,
    ST_DROP_ACC
  } state_t;

endpackage

@@ design/wrap_clamp_triple_box_blur.sv @@
// wrap_clamp_triple_box_blur: load, multi-pass box blur and drain of an rgba image
// depends on wcbb_pkg and wcbb_ram (image store and scratch store)
//
//   port group | direction | handshake            | carries
//   cfg_*      | in        | cfg_valid/cfg_ready  | register index and write data
//   in_*       | in        | in_valid/in_stall    | mode and one rgba pixel (8.8)
//   out_*      | out       | out_valid/out_stall  | one blurred rgba pixel, last flag
//
// a load writes straight into the image store; a drain reads the image store, then the output register.
// the final load starts the blur if the radius is nonzero, which holds in_stall high;
// each pass runs over h rows then w columns, every output pixel going through the
// 16-step divider, with a single read port on each store.
// reset is synchronous and clears the control state; the stores are not cleared.
// a result held by out_stall also holds in_stall high, so a drain never overwrites it.
module wrap_clamp_triple_box_blur #(
  parameter int MAX_WIDTH  = wcbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wcbb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = wcbb_pkg::DEF_MAX_RADIUS,
  parameter int PASS_COUNT = wcbb_pkg::DEF_PASS_COUNT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wcbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcbb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [wcbb_pkg::CH_W-1:0]       in_red_in,
  input  logic [wcbb_pkg::CH_W-1:0]       in_green_in,
  input  logic [wcbb_pkg::CH_W-1:0]       in_blue_in,
  input  logic [wcbb_pkg::CH_W-1:0]       in_alpha_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wcbb_pkg::CH_W-1:0]       out_red_out,
  output logic [wcbb_pkg::CH_W-1:0]       out_green_out,
  output logic [wcbb_pkg::CH_W-1:0]       out_blue_out,
  output logic [wcbb_pkg::CH_W-1:0]       out_alpha_out,
  output logic                            out_last_pixel
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int PW      = $clog2(DEPTH + 1);
  localparam int MW      = AW + 1;
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIMW    = $clog2(MAX_DIM + 1);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int KW      = $clog2(MAX_DIM + MAX_RADIUS + 2) + 1;
  localparam int ACC_W   = wcbb_pkg::CH_W + $clog2(2 * MAX_RADIUS + 2);
  localparam int REMW    = ACC_W + 1;
  localparam int PCW     = $clog2(PASS_COUNT + 1);
  localparam int CH_W    = wcbb_pkg::CH_W;
  localparam int NUM_CH  = wcbb_pkg::NUM_CH;
  localparam int PIX_W   = wcbb_pkg::PIX_W;
  localparam int QCW     = $clog2(CH_W);

  // configuration and control
  logic [8:0]              cfg_w_r;
  logic [7:0]              cfg_h_r, cfg_r_r;
  wcbb_pkg::state_t        state_r, state_nxt;
  logic [PW-1:0]           lp_r, lp_nxt, dp_r, dp_nxt;
  logic                    blur_done_r, blur_done_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // blur datapath
  logic                    horiz_r, horiz_nxt;
  logic [PCW-1:0]          pass_r, pass_nxt;
  logic [DIMW-1:0]         line_r, line_nxt, i_r, i_nxt;
  logic [RW:0]             cnt_r, cnt_nxt;
  logic [RW-1:0]           m_r, m_nxt;
  logic signed [KW-1:0]    ka_r, ka_nxt, kd_r, kd_nxt;
  logic [DIMW-1:0]         pa_r, pa_nxt, pd_r, pd_nxt;
  logic [ACC_W-1:0]        acc_r [NUM_CH];
  logic [ACC_W-1:0]        acc_nxt [NUM_CH];
  logic [REMW-1:0]         rem_r [NUM_CH];
  logic [REMW-1:0]         rem_nxt [NUM_CH];
  logic [CH_W-1:0]         q_r [NUM_CH];
  logic [CH_W-1:0]         q_nxt [NUM_CH];
  logic [REMW-1:0]         dsh_r, dsh_nxt;
  logic [QCW-1:0]          dcnt_r, dcnt_nxt;
  logic [PIX_W-1:0]        out_px_r, out_px_nxt;
  logic                    last_r, last_nxt, out_last_r, out_last_nxt;

  // derived values
  logic [WW-1:0]           w_eff;
  logic [HW-1:0]           h_eff;
  logic [RW-1:0]           r_eff;
  logic [RW:0]             win;
  logic [DIMW-1:0]         n_len, n_lines, posa, posd, pos_sel, mul_a, mul_b;
  logic [PW-1:0]           total, lp_base, lp_adv;
  logic                    ld_wr, ld_full, dr_end;
  logic [AW-1:0]           blur_addr;
  logic [PIX_W-1:0]        q_pix, src_rdata;

  // memories
  logic                    img_we, scr_we;
  logic [AW-1:0]           img_waddr, img_raddr;
  logic [PIX_W-1:0]        img_wdata, img_rdata, scr_rdata;

  function automatic logic [DIMW-1:0] clamp_pos(logic signed [KW-1:0] k,
                                                logic [DIMW-1:0] n);
    logic signed [KW-1:0] top;
    top = $signed(KW'(n)) - $signed(KW'(1));
    if (k < 0) return '0;
    else if (k > top) return n - DIMW'(1);
    else return DIMW'(k);
  endfunction

  function automatic logic [DIMW-1:0] wrap_inc(logic [DIMW-1:0] p, logic [DIMW-1:0] n);
    logic [DIMW-1:0] s;
    s = p + DIMW'(1);
    return (s == n) ? '0 : s;
  endfunction

  // out-of-range register values saturate
  always_comb begin
    if (cfg_w_r == '0) w_eff = WW'(1);
    else if (32'(cfg_w_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_w_r);
    if (cfg_h_r == '0) h_eff = HW'(1);
    else if (32'(cfg_h_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(cfg_h_r);
    if (32'(cfg_r_r) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(cfg_r_r);
  end

  assign win     = {r_eff, 1'b1};
  assign total   = PW'(PW'(w_eff) * PW'(h_eff));
  assign n_len   = horiz_r ? DIMW'(w_eff) : DIMW'(h_eff);
  assign n_lines = horiz_r ? DIMW'(h_eff) : DIMW'(w_eff);

  assign lp_base = blur_done_r ? '0 : lp_r;
  assign ld_wr   = lp_base < total;
  assign lp_adv  = lp_base + PW'(ld_wr);
  assign ld_full = lp_adv >= total;
  assign dr_end  = dp_r >= total;

  // rows wrap, columns clamp
  assign posa = horiz_r ? pa_r : clamp_pos(ka_r, n_len);
  assign posd = horiz_r ? pd_r : clamp_pos(kd_r, n_len);

  always_comb begin
    case (state_r)
      wcbb_pkg::ST_WR:      pos_sel = i_r;
      wcbb_pkg::ST_DROP_RD: pos_sel = posd;
      default:              pos_sel = posa;
    endcase
  end

  assign mul_a     = horiz_r ? line_r : pos_sel;
  assign mul_b     = horiz_r ? pos_sel : line_r;
  assign blur_addr = AW'(MW'(mul_a) * MW'(w_eff) + MW'(mul_b));

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      q_pix[c*CH_W +: CH_W] = q_r[c];
    end
  end

  assign src_rdata = horiz_r ? img_rdata : scr_rdata;
  assign img_raddr = (state_r == wcbb_pkg::ST_IDLE) ? dp_r[AW-1:0] : blur_addr;

  always_comb begin
    state_nxt     = state_r;
    lp_nxt        = lp_r;
    dp_nxt        = dp_r;
    blur_done_nxt = blur_done_r;
    out_valid_nxt = out_valid_r;
    horiz_nxt     = horiz_r;
    pass_nxt      = pass_r;
    line_nxt      = line_r;
    i_nxt         = i_r;
    cnt_nxt       = cnt_r;
    m_nxt         = m_r;
    ka_nxt        = ka_r;
    kd_nxt        = kd_r;
    pa_nxt        = pa_r;
    pd_nxt        = pd_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    dsh_nxt       = dsh_r;
    dcnt_nxt      = dcnt_r;
    out_px_nxt    = out_px_r;
    last_nxt      = last_r;
    out_last_nxt  = out_last_r;
    img_we        = 1'b0;
    img_waddr     = blur_addr;
    img_wdata     = q_pix;
    scr_we        = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      wcbb_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          if (!in_mode) begin
            img_we        = ld_wr;
            img_waddr     = lp_base[AW-1:0];
            img_wdata     = {in_alpha_in, in_blue_in, in_green_in, in_red_in};
            lp_nxt        = lp_adv;
            blur_done_nxt = 1'b0;
            if (blur_done_r) begin
              dp_nxt = '0;
            end
            if (ld_full) begin
              blur_done_nxt = 1'b1;
              lp_nxt        = '0;
              dp_nxt        = '0;
              if (r_eff != '0) begin
                horiz_nxt = 1'b1;
                pass_nxt  = '0;
                line_nxt  = '0;
                m_nxt     = r_eff;
                state_nxt = wcbb_pkg::ST_MOD;
              end
            end
          end else if (blur_done_r) begin
            if (dr_end) begin
              blur_done_nxt = 1'b0;
              dp_nxt        = '0;
              lp_nxt        = '0;
            end else begin
              last_nxt  = (dp_r == total - PW'(1));
              dp_nxt    = dp_r + PW'(1);
              state_nxt = wcbb_pkg::ST_DRAIN;
              if (dp_r + PW'(1) >= total) begin
                blur_done_nxt = 1'b0;
                dp_nxt        = '0;
                lp_nxt        = '0;
              end
            end
          end
        end
      end

      wcbb_pkg::ST_DRAIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_px_nxt    = img_rdata;
          out_last_nxt  = last_r;
          state_nxt     = wcbb_pkg::ST_IDLE;
        end
      end

      // start of a line: reduce r modulo the line length for the wrapped start
      wcbb_pkg::ST_MOD: begin
        if (KW'(m_r) >= KW'(n_len)) begin
          m_nxt = RW'(KW'(m_r) - KW'(n_len));
        end else begin
          pa_nxt    = (m_r == '0) ? '0 : DIMW'(KW'(n_len) - KW'(m_r));
          pd_nxt    = (m_r == '0) ? '0 : DIMW'(KW'(n_len) - KW'(m_r));
          ka_nxt    = -$signed(KW'(r_eff));
          kd_nxt    = -$signed(KW'(r_eff));
          cnt_nxt   = win;
          i_nxt     = '0;
          for (int c = 0; c < NUM_CH; c++) begin
            acc_nxt[c] = '0;
          end
          state_nxt = wcbb_pkg::ST_INIT_RD;
        end
      end

      wcbb_pkg::ST_INIT_RD: begin
        ka_nxt    = ka_r + $signed(KW'(1));
        pa_nxt    = wrap_inc(pa_r, n_len);
        state_nxt = wcbb_pkg::ST_INIT_ACC;
      end

      wcbb_pkg::ST_INIT_ACC: begin
        for (int c = 0; c < NUM_CH; c++) begin
          acc_nxt[c] = acc_r[c] + ACC_W'(src_rdata[c*CH_W +: CH_W]);
        end
        cnt_nxt   = cnt_r - (RW+1)'(1);
        state_nxt = (cnt_r == (RW+1)'(1)) ? wcbb_pkg::ST_DIV_LD : wcbb_pkg::ST_INIT_RD;
      end

      // rounding: (sum + r) / (2r + 1), one quotient bit a cycle
      wcbb_pkg::ST_DIV_LD: begin
        for (int c = 0; c < NUM_CH; c++) begin
          rem_nxt[c] = REMW'(acc_r[c]) + REMW'(r_eff);
        end
        dsh_nxt   = REMW'(win) << (CH_W - 1);
        dcnt_nxt  = '0;
        state_nxt = wcbb_pkg::ST_DIV;
      end

      wcbb_pkg::ST_DIV: begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (rem_r[c] >= dsh_r) begin
            rem_nxt[c] = rem_r[c] - dsh_r;
            q_nxt[c]   = {q_r[c][CH_W-2:0], 1'b1};
          end else begin
            q_nxt[c]   = {q_r[c][CH_W-2:0], 1'b0};
          end
        end
        dsh_nxt  = dsh_r >> 1;
        dcnt_nxt = dcnt_r + QCW'(1);
        if (dcnt_r == QCW'(CH_W - 1)) begin
          state_nxt = wcbb_pkg::ST_WR;
        end
      end

      wcbb_pkg::ST_WR: begin
        if (horiz_r) begin
          scr_we = 1'b1;
        end else begin
          img_we = 1'b1;
        end
        if (i_r == n_len - DIMW'(1)) begin
          m_nxt     = r_eff;
          state_nxt = wcbb_pkg::ST_MOD;
          if (line_r + DIMW'(1) == n_lines) begin
            line_nxt = '0;
            if (horiz_r) begin
              horiz_nxt = 1'b0;
            end else if (pass_r == PCW'(PASS_COUNT - 1)) begin
              state_nxt = wcbb_pkg::ST_IDLE;
            end else begin
              horiz_nxt = 1'b1;
              pass_nxt  = pass_r + PCW'(1);
            end
          end else begin
            line_nxt = line_r + DIMW'(1);
          end
        end else begin
          state_nxt = wcbb_pkg::ST_ADD_RD;
        end
      end

      wcbb_pkg::ST_ADD_RD: begin
        state_nxt = wcbb_pkg::ST_ADD_ACC;
      end

      wcbb_pkg::ST_ADD_ACC: begin
        for (int c = 0; c < NUM_CH; c++) begin
          acc_nxt[c] = acc_r[c] + ACC_W'(src_rdata[c*CH_W +: CH_W]);
        end
        state_nxt = wcbb_pkg::ST_DROP_RD;
      end

      wcbb_pkg::ST_DROP_RD: begin
        state_nxt = wcbb_pkg::ST_DROP_ACC;
      end

      wcbb_pkg::ST_DROP_ACC: begin
        for (int c = 0; c < NUM_CH; c++) begin
          acc_nxt[c] = acc_r[c] - ACC_W'(src_rdata[c*CH_W +: CH_W]);
        end
        ka_nxt    = ka_r + $signed(KW'(1));
        kd_nxt    = kd_r + $signed(KW'(1));
        pa_nxt    = wrap_inc(pa_r, n_len);
        pd_nxt    = wrap_inc(pd_r, n_len);
        i_nxt     = i_r + DIMW'(1);
        state_nxt = wcbb_pkg::ST_DIV_LD;
      end

      default: begin
        state_nxt = wcbb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wcbb_pkg::ST_IDLE;
      cfg_w_r     <= wcbb_pkg::RST_WIDTH;
      cfg_h_r     <= wcbb_pkg::RST_HEIGHT;
      cfg_r_r     <= wcbb_pkg::RST_RADIUS;
      lp_r        <= '0;
      dp_r        <= '0;
      blur_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lp_r        <= lp_nxt;
      dp_r        <= dp_nxt;
      blur_done_r <= blur_done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wcbb_pkg::CFG_WIDTH:  cfg_w_r <= cfg_data;
          wcbb_pkg::CFG_HEIGHT: cfg_h_r <= cfg_data[7:0];
          wcbb_pkg::CFG_RADIUS: cfg_r_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    horiz_r    <= horiz_nxt;
    pass_r     <= pass_nxt;
    line_r     <= line_nxt;
    i_r        <= i_nxt;
    cnt_r      <= cnt_nxt;
    m_r        <= m_nxt;
    ka_r       <= ka_nxt;
    kd_r       <= kd_nxt;
    pa_r       <= pa_nxt;
    pd_r       <= pd_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    dsh_r      <= dsh_nxt;
    dcnt_r     <= dcnt_nxt;
    out_px_r   <= out_px_nxt;
    last_r     <= last_nxt;
    out_last_r <= out_last_nxt;
  end

  wcbb_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_image_store (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (img_wdata),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  wcbb_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_scratch_store (
    .clk   (clk),
    .we    (scr_we),
    .waddr (blur_addr),
    .wdata (q_pix),
    .raddr (blur_addr),
    .rdata (scr_rdata)
  );

  assign cfg_ready      = (state_r == wcbb_pkg::ST_IDLE);
  // the drain read is not held, so no request while a result waits
  assign in_stall       = (state_r != wcbb_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign out_valid      = out_valid_r;
  assign out_red_out    = out_px_r[0*CH_W +: CH_W];
  assign out_green_out  = out_px_r[1*CH_W +: CH_W];
  assign out_blue_out   = out_px_r[2*CH_W +: CH_W];
  assign out_alpha_out  = out_px_r[3*CH_W +: CH_W];
  assign out_last_pixel = out_last_r;

  // divider leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wcbb_pkg::ST_WR |-> rem_r[0] < REMW'(win))
    else $error("divider remainder not below window size");

  // pass counter stays in range while blurring
  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != wcbb_pkg::ST_IDLE && state_r != wcbb_pkg::ST_DRAIN)
      |-> pass_r < PCW'(PASS_COUNT))
    else $error("pass counter out of range");

  // finishing the last pass leaves the image ready to drain
  a_blur_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wcbb_pkg::ST_WR && state_nxt == wcbb_pkg::ST_IDLE) |=> blur_done_r)
    else $error("blur finished without the image marked ready");

endmodule

@@ design/wcbb_ram.sv @@
// wcbb_ram: generic single-write, single-read ram with registered read data
// no dependencies
module wcbb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
